// ----- sv/block_heart_rate_estimator_defines.svh -----
// Assertion macros used by the checker file.
`ifndef BLOCK_HEART_RATE_ESTIMATOR_DEFINES_SVH
`define BLOCK_HEART_RATE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HRE_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HRE_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/hre_pkg.sv -----
// Shared widths, constants and types of the heart rate estimator.
package hre_pkg;
	localparam int SAMPLE_W          = 24;
	localparam int RATE_W            = 14;
	localparam int BEATS_W           = 7;
	localparam int POS_W             = 8;
	localparam int SUM_W             = 28;
	localparam int TDATA_IN_W        = 24;
	localparam int TDATA_OUT_W       = 24;
	localparam int BLOCK_LEN_DEFAULT = 200;
	localparam int RATE_SCALE        = 26400;
	localparam int RECIP_SHIFT       = 31;
	localparam logic [SUM_W-1:0]    RECIP10      = 28'd214748365;
	localparam logic [SAMPLE_W-1:0] THRESH_RESET = 24'd1000;

	typedef struct packed {
		logic               block_end;
		logic [BEATS_W-1:0] beats;
	} hre_blk_t;
endpackage

// ----- sv/block_heart_rate_estimator.sv -----
// Heart rate estimator from blocks of infrared samples: top level.
// One sample is taken per cycle on s_axis unless the input stalls; each
// passes an input register and is smoothed, compared for a peak and counted
// as it leaves that register, so samples stream back to back. After every
// BLOCK_LEN samples one result leaves on m_axis from an output register,
// loaded as the last sample of the block leaves the input register, with the
// beat count and the rate looked up from it. The input side keeps accepting
// while a result waits; it stalls only when a block-ending sample meets a
// result not yet taken. The user must write the peak threshold on the cfg
// channel, always ready, only while the block is idle; the block does not enforce it.
module block_heart_rate_estimator #(
	parameter int BLOCK_LEN = hre_pkg::BLOCK_LEN_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [hre_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // [23:0] ir_sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [hre_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [13:0] rate_centi_bpm,
	                                                       // [20:14] beat_count, zero
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hre_pkg::SAMPLE_W-1:0]    cfg_data
);
	import hre_pkg::*;

	logic                valid_s1;
	logic [SAMPLE_W-1:0] x_s1;
	logic [SAMPLE_W-1:0] thresh_q;
	logic                out_valid_q;
	logic [BEATS_W-1:0]  beats_q;
	logic [RATE_W-1:0]   rate;
	logic                fire_s1;
	hre_blk_t            blk;

	assign cfg_ready     = 1'b1;
	assign fire_s1       = valid_s1 && (!blk.block_end || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;

	hre_tracker #(.BLOCK_LEN(BLOCK_LEN)) u_tracker (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (fire_s1),
		.x         (x_s1),
		.threshold (thresh_q),
		.blk       (blk)
	);

	hre_rate_lut #(.BLOCK_LEN(BLOCK_LEN)) u_rate_lut (
		.beats (beats_q),
		.rate  (rate)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(TDATA_OUT_W-RATE_W-BEATS_W)'(0), beats_q, rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			thresh_q    <= THRESH_RESET;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (fire_s1 && blk.block_end) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				thresh_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			x_s1 <= s_axis_tdata[SAMPLE_W-1:0];
		end
		if (fire_s1 && blk.block_end) begin
			beats_q <= blk.beats;
		end
	end
endmodule

// ----- sv/hre_smoother.sv -----
// Exponential smoothing step: floor((x + 9*prev) / 10) by reciprocal multiply.
module hre_smoother (
	input  logic [hre_pkg::SAMPLE_W-1:0] prev,
	input  logic [hre_pkg::SAMPLE_W-1:0] x,
	output logic [hre_pkg::SAMPLE_W-1:0] smooth
);
	import hre_pkg::*;

	logic [SUM_W-1:0]   sum;
	logic [2*SUM_W-1:0] prod;

	assign sum    = SUM_W'(x) + SUM_W'({prev, 3'b000}) + SUM_W'(prev);
	assign prod   = (2*SUM_W)'(sum) * (2*SUM_W)'(RECIP10);
	assign smooth = prod[RECIP_SHIFT +: SAMPLE_W];
endmodule

// ----- sv/hre_tracker.sv -----
// Block position, smoothing history and peak tally.
module hre_tracker #(
	parameter int BLOCK_LEN = hre_pkg::BLOCK_LEN_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [hre_pkg::SAMPLE_W-1:0] x,
	input  logic [hre_pkg::SAMPLE_W-1:0] threshold,
	output hre_pkg::hre_blk_t            blk
);
	import hre_pkg::*;

	logic [POS_W-1:0]    pos_q;
	logic [SAMPLE_W-1:0] last_q;
	logic [SAMPLE_W-1:0] before_q;
	logic [BEATS_W-1:0]  tally_q;
	logic [SAMPLE_W-1:0] smooth;
	logic [SAMPLE_W-1:0] cur;
	logic [POS_W:0]      pos_inc;
	logic                peak;
	logic [BEATS_W-1:0]  tally_nx;

	hre_smoother u_smoother (
		.prev   (last_q),
		.x      (x),
		.smooth (smooth)
	);

	assign cur      = (pos_q == '0) ? x : smooth;
	assign peak     = (pos_q >= POS_W'(2)) && (last_q > before_q) && (last_q > cur)
		&& (last_q > threshold);
	assign tally_nx = tally_q + BEATS_W'(peak);
	assign pos_inc  = {1'b0, pos_q} + (POS_W+1)'(1);

	assign blk.block_end = pos_inc >= (POS_W+1)'(BLOCK_LEN);
	assign blk.beats     = tally_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			tally_q <= '0;
		end else if (adv) begin
			if (blk.block_end) begin
				pos_q   <= '0;
				tally_q <= '0;
			end else begin
				pos_q   <= pos_inc[POS_W-1:0];
				tally_q <= tally_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			before_q <= last_q;
			last_q   <= cur;
		end
	end
endmodule

// ----- sv/hre_rate_lut.sv -----
// Beat count to rate in hundredths of a BPM, as a constant table.
module hre_rate_lut #(
	parameter int BLOCK_LEN = hre_pkg::BLOCK_LEN_DEFAULT
) (
	input  logic [hre_pkg::BEATS_W-1:0] beats,
	output logic [hre_pkg::RATE_W-1:0]  rate
);
	import hre_pkg::*;

	logic [RATE_W-1:0] lut [2**BEATS_W];

	for (genvar i = 0; i < 2**BEATS_W; i++) begin : g_lut
		localparam int unsigned RateVal = (i * RATE_SCALE) / BLOCK_LEN;
		assign lut[i] = RATE_W'(RateVal);
	end

	assign rate = lut[beats];
endmodule

// ----- sv/hre_checker.sv -----
// Port-level checks of the heart rate estimator and their bind.
`include "block_heart_rate_estimator_defines.svh"

module hre_checker #(
	parameter int BLOCK_LEN = hre_pkg::BLOCK_LEN_DEFAULT
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [hre_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
	import hre_pkg::*;

	logic [BEATS_W-1:0] beats;
	logic [RATE_W-1:0]  rate;

	assign rate  = m_axis_tdata[RATE_W-1:0];
	assign beats = m_axis_tdata[RATE_W +: BEATS_W];

	`HRE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`HRE_ASSERT_IMP(a_beats_bound, m_axis_tvalid,
		beats <= BEATS_W'((BLOCK_LEN - 1) / 2), "more beats than a block can hold")
	`HRE_ASSERT_IMP(a_zero_rate, m_axis_tvalid && beats == '0,
		rate == '0, "nonzero rate with no beats")
	`HRE_ASSERT_IMP(a_rise_after_in, $rose(m_axis_tvalid),
		$past(s_axis_tvalid && s_axis_tready, 2), "result without a sample transfer")
endmodule

bind block_heart_rate_estimator hre_checker #(.BLOCK_LEN(BLOCK_LEN)) u_hre_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
